FILE: design/slm_pkg.sv
// ----------------------------------------------------------------------------
// slm_pkg - sorted list merge package
// Shared widths, kind codes, sequencer states and buffer status type.
// ----------------------------------------------------------------------------
package slm_pkg;

  localparam int SEQ_DEPTH = 32;
  localparam int DATA_W    = 32;
  localparam int KIND_W    = 2;
  localparam int IDX_W     = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
  localparam int CNT_W     = $clog2(SEQ_DEPTH + 1);

  // input transaction kinds
  typedef enum logic [KIND_W-1:0] {
    KIND_FIRST  = 2'd0,
    KIND_SECOND = 2'd1,
    KIND_MERGE  = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_t;

  // merge sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_t;

  // status of one sequence buffer as seen by the sequencer
  typedef struct packed {
    logic [CNT_W-1:0]         count;
    logic                     full;
    logic signed [DATA_W-1:0] rd_data;
  } buf_stat_t;

endpackage

FILE: design/slm_if.sv
// ----------------------------------------------------------------------------
// slm_if - sorted list merge channels
// Valid/ready channels for input items and merge results.
// ----------------------------------------------------------------------------
interface slm_in_if;
  import slm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface slm_out_if;
  import slm_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] merged_value;
  logic                     last;
  logic                     empty_res;
  logic                     overflow;

  modport source (output valid, output merged_value, output last, output empty_res,
                  output overflow, input ready);
  modport sink   (input valid, input merged_value, input last, input empty_res,
                  input overflow, output ready);
endinterface

FILE: design/sorted_list_merge_unit.sv
// ----------------------------------------------------------------------------
// sorted_list_merge_unit - two-way merge of sorted sequences
// Collects two ascending sequences and emits their merge on request.
//
//   channel   dir   payload                                  role
//   items     in    kind, value                              append or merge
//   results   out   merged_value, last, empty_res, overflow  merged elements
//
// An append transaction is taken while idle and items stays ready for the next.
// A merge yields n results for n stored elements (one when both are empty),
// produced by the shared comparator walking the two buffer read ports;
// items is not ready meanwhile.
// A stall on results holds the walk; the result register keeps its payload.
// Reset clears the fill counts, the overflow flag and the sequencer; buffer
// contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_list_merge_unit (
  input  logic      clk,
  input  logic      rst,
  slm_in_if.sink    items,
  slm_out_if.source results
);
  import slm_pkg::*;

  logic               accept, wr_first, wr_second, start, drop, clear, busy;
  logic [IDX_W-1:0]   first_addr, second_addr;
  buf_stat_t          first_stat, second_stat;

  // input decode
  assign items.ready = !busy;
  assign accept      = items.valid && items.ready;
  assign wr_first    = accept && (items.kind == KIND_FIRST);
  assign wr_second   = accept && (items.kind == KIND_SECOND);
  assign start       = accept && (items.kind == KIND_MERGE);
  assign drop        = (wr_first && first_stat.full) || (wr_second && second_stat.full);

  // first sequence buffer
  slm_buffer u_first (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_first),
    .wr_data (items.value),
    .clear   (clear),
    .rd_addr (first_addr),
    .stat    (first_stat)
  );

  // second sequence buffer
  slm_buffer u_second (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_second),
    .wr_data (items.value),
    .clear   (clear),
    .rd_addr (second_addr),
    .stat    (second_stat)
  );

  // merge sequencer
  slm_merge_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .drop        (drop),
    .first_stat  (first_stat),
    .second_stat (second_stat),
    .first_addr  (first_addr),
    .second_addr (second_addr),
    .clear       (clear),
    .busy        (busy),
    .res         (results)
  );

endmodule

FILE: design/slm_buffer.sv
// ----------------------------------------------------------------------------
// slm_buffer - sequence buffer
// Element memory with append port, fill count and registered read port.
// ----------------------------------------------------------------------------
module slm_buffer (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic signed [slm_pkg::DATA_W-1:0] wr_data,
  input  logic                              clear,
  input  logic [slm_pkg::IDX_W-1:0]         rd_addr,
  output slm_pkg::buf_stat_t                stat
);
  import slm_pkg::*;

  logic signed [DATA_W-1:0] mem [SEQ_DEPTH];
  logic [CNT_W-1:0]         count;
  logic                     full;
  logic signed [DATA_W-1:0] rd_data;

  assign full = (count == CNT_W'(SEQ_DEPTH));

  // fill count, appends beyond the depth are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (clear) begin
      count <= '0;
    end else if (wr_en && !full) begin
      count <= count + CNT_W'(1);
    end
  end

  // memory write at the fill position
  always_ff @(posedge clk) begin
    if (wr_en && !full) begin
      mem[count[IDX_W-1:0]] <= wr_data;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

  assign stat.count   = count;
  assign stat.full    = full;
  assign stat.rd_data = rd_data;

endmodule

FILE: design/slm_merge_seq.sv
// ----------------------------------------------------------------------------
// slm_merge_seq - merge sequencer
// Walks both buffers with one shared signed comparator and drives the
// result register, one result per cycle while the sink takes them.
// ----------------------------------------------------------------------------
module slm_merge_seq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic                      drop,
  input  slm_pkg::buf_stat_t        first_stat,
  input  slm_pkg::buf_stat_t        second_stat,
  output logic [slm_pkg::IDX_W-1:0] first_addr,
  output logic [slm_pkg::IDX_W-1:0] second_addr,
  output logic                      clear,
  output logic                      busy,
  slm_out_if.source                 res
);
  import slm_pkg::*;

  state_t           state, state_next;
  logic [CNT_W-1:0] i, i_next, i_inc;
  logic [CNT_W-1:0] j, j_next, j_inc;
  logic             dropped;
  logic             has_first, has_second, take_first, take_second;
  logic             can_emit, emit, last_c;

  // state register and read pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      i     <= '0;
      j     <= '0;
    end else begin
      state <= state_next;
      i     <= i_next;
      j     <= j_next;
    end
  end

  // head compare, pointer advance and next state
  always_comb begin
    has_first   = (i < first_stat.count);
    has_second  = (j < second_stat.count);
    take_first  = has_first && (!has_second || (first_stat.rd_data < second_stat.rd_data));
    take_second = has_second && !take_first;
    i_inc       = i + CNT_W'(take_first);
    j_inc       = j + CNT_W'(take_second);
    last_c      = (i_inc == first_stat.count) && (j_inc == second_stat.count);
    can_emit    = !res.valid || res.ready;
    emit        = 1'b0;
    state_next  = state;
    i_next      = i;
    j_next      = j;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (can_emit) begin
          emit = 1'b1;
          if (last_c) begin
            state_next = ST_IDLE;
            i_next     = '0;
            j_next     = '0;
          end else begin
            i_next = i_inc;
            j_next = j_inc;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
        i_next     = '0;
        j_next     = '0;
      end
    endcase
  end

  // reads follow the next pointers so the heads are ready in the cycle after
  assign first_addr  = i_next[IDX_W-1:0];
  assign second_addr = j_next[IDX_W-1:0];
  assign clear       = emit && last_c;
  assign busy        = (state != ST_IDLE);

  // dropped append flag
  always_ff @(posedge clk) begin
    if (rst) begin
      dropped <= 1'b0;
    end else if (clear) begin
      dropped <= 1'b0;
    end else if (drop) begin
      dropped <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (emit) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      res.merged_value <= take_first  ? first_stat.rd_data :
                          take_second ? second_stat.rd_data : '0;
      res.last         <= last_c;
      res.empty_res    <= !has_first && !has_second;
      res.overflow     <= dropped;
    end
  end

  // pointers rest at zero between merges
  a_idle_ptrs: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (i == '0 && j == '0))
    else $error("read pointers not at zero while idle");

  // pointers never pass the fill counts during a merge
  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (i <= first_stat.count && j <= second_stat.count))
    else $error("read pointer beyond fill count");

  // the final result ends the merge and empties the buffers
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (emit && last_c) |=> (state == ST_IDLE && first_stat.count == '0
                          && second_stat.count == '0 && !dropped))
    else $error("merge did not end after last result");

  // a merge item starts the walk
  a_start: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE && start) |=> (state == ST_EMIT))
    else $error("merge did not start");

endmodule
